[design/gmp_pkg.sv]
// Shared types, widths and register codes for the grid max path sum unit.
package gmp_pkg;

  localparam int VAL_W     = 32;
  localparam int SUM_W     = 48;
  localparam int ROWS_W    = 9;
  localparam int COLS_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = COLS_W;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 1024;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1
  } cfg_idx_t;

  // Where a cell sits in the grid, as far as the datapath cares.
  typedef struct packed {
    logic first_col;
    logic last_row;
    logic last_col;
    logic has_low;
  } pos_t;

endpackage

[design/gmp_seq.sv]
// Grid size registers and cell position counters.
module gmp_seq import gmp_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_dat,
  input  logic                 advance,
  output logic                 restart,
  output pos_t                 pos,
  output logic [RW-1:0]        row,
  output logic [RW-1:0]        rd_addr
);

  logic [RW-1:0] last_row_r, last_row_nxt;
  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [31:0]   rows_cl, cols_cl;
  logic [31:0]   rows_in, cols_in;

  assign rows_in = 32'(cfg_dat[ROWS_W-1:0]);
  assign cols_in = 32'(cfg_dat[COLS_W-1:0]);

  // Clamp to 1..MAX; zero acts as one.
  always_comb begin
    rows_cl = rows_in;
    if (rows_in == 32'd0) rows_cl = 32'd1;
    else if (rows_in > 32'(MAX_ROWS)) rows_cl = 32'(MAX_ROWS);
    cols_cl = cols_in;
    if (cols_in == 32'd0) cols_cl = 32'd1;
    else if (cols_in > 32'(MAX_COLS)) cols_cl = 32'(MAX_COLS);
  end

  assign restart = cfg_we && (cfg_idx == CFG_ROWS || cfg_idx == CFG_COLS);

  always_comb begin
    last_row_nxt = last_row_r;
    last_col_nxt = last_col_r;
    if (cfg_we && cfg_idx == CFG_ROWS) last_row_nxt = RW'(rows_cl - 32'd1);
    if (cfg_we && cfg_idx == CFG_COLS) last_col_nxt = CW'(cols_cl - 32'd1);
  end

  assign row = row_cnt_r;
  assign pos.first_col = (col_cnt_r == '0);
  assign pos.last_row  = (row_cnt_r == last_row_r);
  assign pos.last_col  = (col_cnt_r == last_col_r);
  assign pos.has_low   = (row_cnt_r != '0);

  // Fetch the previous column's entry one row up, wrapping at the column end.
  assign rd_addr = pos.last_row ? '0 : row_cnt_r + RW'(1);

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (restart) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end else if (advance) begin
      if (pos.last_row) begin
        row_cnt_nxt = '0;
        col_cnt_nxt = pos.last_col ? '0 : col_cnt_r + CW'(1);
      end else begin
        row_cnt_nxt = row_cnt_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= '0;
      last_col_r <= '0;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
    end else begin
      last_row_r <= last_row_nxt;
      last_col_r <= last_col_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
    end
  end

endmodule

[design/gmp_colmem.sv]
// Column store: one best sum per row, write-first registered read.
module gmp_colmem import gmp_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ROWS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sum_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output sum_t          q
);

  sum_t mem [DEPTH];
  sum_t q_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Bypass a write to the same row in the same cycle.
  always_ff @(posedge clk) begin
    if (re) q_r <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

  assign q = q_r;

endmodule

[design/gmp_cell.sv]
// Cell datapath: three-way neighbor max, add, neighbor window, last-column max.
module gmp_cell import gmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic restart,
  input  val_t cell_val,
  input  pos_t pos,
  input  sum_t up_q,
  output sum_t cell_sum,
  output sum_t grid_best
);

  sum_t mid_r;
  sum_t low_r;
  sum_t best_r, best_nxt;
  sum_t nb_max;
  sum_t val_ext;

  assign val_ext = {{(SUM_W-VAL_W){cell_val[VAL_W-1]}}, cell_val};

  always_comb begin
    nb_max = mid_r;
    if (pos.has_low && low_r > nb_max) nb_max = low_r;
    if (!pos.last_row && up_q > nb_max) nb_max = up_q;
    cell_sum  = pos.first_col ? val_ext : val_ext + nb_max;
    grid_best = (pos.last_col && cell_sum > best_r) ? cell_sum : best_r;
  end

  always_comb begin
    best_nxt = best_r;
    if (restart) best_nxt = SUM_MIN;
    else if (step && pos.last_row && pos.last_col) best_nxt = SUM_MIN;
    else if (step) best_nxt = grid_best;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) best_r <= SUM_MIN;
    else        best_r <= best_nxt;
  end

  // Slide the window of previous-column sums down one row per cell.
  // A single-row grid feeds its own result back as the next cell's left neighbor.
  always_ff @(posedge clk) begin
    if (step) begin
      low_r <= mid_r;
      mid_r <= (pos.last_row && !pos.has_low) ? cell_sum : up_q;
    end
  end

endmodule

[design/grid_max_path_sum_dp_unit.sv]
// Top level of the grid max path sum unit.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, in_cell_value      | in
//  result  | out_valid, out_ready, out_best_sum     | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One cell word per cycle while in_ready is high: a cell is registered on accept and
// finished once the datapath takes it, against the column store read issued at accept.
// After the grid's final cell is taken, its result passes the cell word register, then out_sum_r.
// in_ready drops only while a finished result waits and another grid end is ready.
// Reset is synchronous; the column store needs no clearing, cfg_ready is always high.
module grid_max_path_sum_dp_unit import gmp_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  val_t                 in_cell_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sum_t                 out_best_sum,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic          in_acc;
  logic          restart;
  pos_t          pos;
  logic [RW-1:0] row;
  logic [RW-1:0] rd_addr;

  logic          b_valid_r, b_valid_nxt;
  val_t          b_val_r;
  pos_t          b_pos_r;
  logic [RW-1:0] b_row_r;
  logic          b_emit, b_go;

  sum_t          up_q;
  sum_t          cell_sum;
  sum_t          grid_best;

  logic          out_valid_r, out_valid_nxt;
  sum_t          out_sum_r;

  assign cfg_ready = 1'b1;

  assign b_emit   = b_pos_r.last_row && b_pos_r.last_col;
  assign b_go     = b_valid_r && (!b_emit || !out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_go;
  assign in_acc   = in_valid && in_ready;

  gmp_seq #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .RW      (RW),
    .CW      (CW)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_valid && cfg_ready),
    .cfg_idx(cfg_index),
    .cfg_dat(cfg_data),
    .advance(in_acc),
    .restart(restart),
    .pos    (pos),
    .row    (row),
    .rd_addr(rd_addr)
  );

  gmp_colmem #(
    .DEPTH(MAX_ROWS),
    .AW   (RW)
  ) u_mem (
    .clk  (clk),
    .we   (b_go),
    .waddr(b_row_r),
    .wdata(cell_sum),
    .re   (in_acc),
    .raddr(rd_addr),
    .q    (up_q)
  );

  gmp_cell u_cell (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (b_go),
    .restart  (restart),
    .cell_val (b_val_r),
    .pos      (b_pos_r),
    .up_q     (up_q),
    .cell_sum (cell_sum),
    .grid_best(grid_best)
  );

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_acc)    b_valid_nxt = 1'b1;
    else if (b_go) b_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (b_go && b_emit)            out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the cell word and its position until the datapath takes it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_val_r <= in_cell_value;
      b_pos_r <= pos;
      b_row_r <= row;
    end
    if (b_go && b_emit) out_sum_r <= grid_best;
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_sum_r;

endmodule

[design/gmp_checker.sv]
// Port-level checks for the grid max path sum unit, bound to the top level.
module gmp_checker import gmp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sum_t out_best_sum
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_sum))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a blocked result.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // A fresh result follows an accepted cell word, through the cell word and result registers.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding cell word");

endmodule

bind grid_max_path_sum_dp_unit gmp_checker u_gmp_checker (.*);
